@@ rtl/srsg_pkg.sv @@
// ============================================================================
// srsg_pkg
// Shared types, constants and tables for the stepper ramp step generator.
// ============================================================================
package srsg_pkg;

    // Number of steps in each of the acceleration and deceleration ramps.
    localparam int RAMP_STEPS = 16;
    localparam int RAMP_IDX_W = $clog2(RAMP_STEPS);

    localparam int STEP_W  = 16;
    localparam int DELAY_W = 8;
    localparam int COIL_W  = 8;

    localparam logic [STEP_W-1:0]     RAMP_LEN      = STEP_W'(RAMP_STEPS);
    localparam logic [STEP_W-1:0]     MIN_RAMP_MOVE = STEP_W'(2 * RAMP_STEPS);
    localparam logic [RAMP_IDX_W-1:0] RAMP_LAST     = RAMP_IDX_W'(RAMP_STEPS - 1);
    localparam logic [DELAY_W-1:0]    CRUISE_RESET  = DELAY_W'(6);

    // Item kinds carried on the input tuser.
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_RAMPED = 2'd1;
    localparam logic [1:0] MODE_FIXED  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [STEP_W-1:0]  step_count;
        logic               direction;
        logic [DELAY_W-1:0] step_delay;
    } t_item;

    typedef struct packed {
        logic [COIL_W-1:0] coil_pattern;
        logic              stepped;
        logic              busy_res;
        logic              rejected;
    } t_result;

    // Winding drive byte for each of the four phases.
    function automatic logic [COIL_W-1:0] coil_lookup(input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            2'd0:    pat = 8'hD8;
            2'd1:    pat = 8'hB8;
            2'd2:    pat = 8'hB4;
            2'd3:    pat = 8'hD4;
            default: pat = 8'hD8;
        endcase
        return pat;
    endfunction

    // Acceleration delay in ticks for a ramp position.
    function automatic logic [DELAY_W-1:0] accel_lookup(input logic [RAMP_IDX_W-1:0] idx);
        logic [DELAY_W-1:0] d;
        case (idx)
            4'd0:    d = 8'd17;
            4'd1:    d = 8'd17;
            4'd2:    d = 8'd16;
            4'd3:    d = 8'd16;
            4'd4:    d = 8'd15;
            4'd5:    d = 8'd14;
            4'd6:    d = 8'd13;
            4'd7:    d = 8'd12;
            4'd8:    d = 8'd11;
            4'd9:    d = 8'd10;
            4'd10:   d = 8'd9;
            4'd11:   d = 8'd8;
            4'd12:   d = 8'd8;
            4'd13:   d = 8'd7;
            4'd14:   d = 8'd7;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/srsg_core.sv @@
// ============================================================================
// srsg_core
// Move state, cruise register and the combinational update for one item.
// ============================================================================
module srsg_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [srsg_pkg::DELAY_W-1:0] i_cfg_wr_data,
    input  logic                         i_en,
    input  srsg_pkg::t_item              i_item,
    output srsg_pkg::t_result            o_result
);

    logic [srsg_pkg::DELAY_W-1:0] r_cruise;
    logic [1:0]                   r_phase,       n_phase;
    logic                         r_moving,      n_moving;
    logic                         r_dir,         n_dir;
    logic                         r_ramped,      n_ramped;
    logic [srsg_pkg::STEP_W-1:0]  r_taken,       n_taken;
    logic [srsg_pkg::STEP_W-1:0]  r_total,       n_total;
    logic [srsg_pkg::DELAY_W-1:0] r_fixed,       n_fixed;
    logic [srsg_pkg::DELAY_W-1:0] r_ticks,       n_ticks;

    logic                         is_tick;
    logic                         is_start;
    logic                         start_ok;
    logic [srsg_pkg::STEP_W-1:0]  start_total;
    logic                         tick_due;
    logic                         more_steps;
    logic                         do_step;
    logic                         do_end;
    logic [srsg_pkg::STEP_W-1:0]  rev_pos;
    logic [srsg_pkg::RAMP_IDX_W-1:0] ramp_idx;
    logic [srsg_pkg::DELAY_W-1:0] step_delay;

    assign is_tick  = (i_item.mode == srsg_pkg::MODE_TICK);
    assign is_start = (i_item.mode == srsg_pkg::MODE_RAMPED) ||
                      (i_item.mode == srsg_pkg::MODE_FIXED);
    assign start_ok = is_start && !r_moving;

    // A short ramped move is stretched to cover both ramps.
    assign start_total = ((i_item.mode == srsg_pkg::MODE_RAMPED) &&
                          (i_item.step_count < srsg_pkg::MIN_RAMP_MOVE)) ?
                         srsg_pkg::MIN_RAMP_MOVE : i_item.step_count;

    assign tick_due   = is_tick && r_moving && (r_ticks <= 8'd1);
    assign more_steps = (r_taken < r_total);

    always_comb begin
        // Move description as seen by this item: freshly latched on a start.
        n_ramped = r_ramped;
        n_dir    = r_dir;
        n_total  = r_total;
        n_fixed  = r_fixed;
        if (start_ok) begin
            n_ramped = (i_item.mode == srsg_pkg::MODE_RAMPED);
            n_dir    = i_item.direction;
            n_total  = start_total;
            n_fixed  = n_ramped ? '0 :
                       ((i_item.step_delay == '0) ? 8'd1 : i_item.step_delay);
        end
    end

    assign do_step = start_ok ? (start_total != '0) : (tick_due && more_steps);
    assign do_end  = tick_due && !more_steps;

    // Deceleration reads the table backwards from the end of the move.
    always_comb begin
        logic [srsg_pkg::STEP_W-1:0] pos;
        pos     = start_ok ? '0 : r_taken;
        rev_pos = n_total - pos - 16'd1;
        if (pos < srsg_pkg::RAMP_LEN) begin
            ramp_idx = pos[srsg_pkg::RAMP_IDX_W-1:0];
        end else if (rev_pos >= srsg_pkg::RAMP_LEN) begin
            ramp_idx = srsg_pkg::RAMP_LAST;
        end else begin
            ramp_idx = rev_pos[srsg_pkg::RAMP_IDX_W-1:0];
        end
        if (!n_ramped) begin
            step_delay = n_fixed;
        end else if ((pos < srsg_pkg::RAMP_LEN) ||
                     (pos >= n_total - srsg_pkg::RAMP_LEN)) begin
            step_delay = srsg_pkg::accel_lookup(ramp_idx);
        end else begin
            step_delay = (r_cruise == '0) ? 8'd1 : r_cruise;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_moving = r_moving;
        n_taken  = r_taken;
        n_ticks  = r_ticks;
        if (start_ok) begin
            n_moving = (start_total != '0);
            n_taken  = '0;
            n_ticks  = '0;
        end else if (do_end) begin
            n_moving = 1'b0;
            n_ticks  = '0;
        end else if (is_tick && r_moving && !tick_due) begin
            n_ticks = r_ticks - 8'd1;
        end
        if (do_step) begin
            n_phase = n_dir ? (r_phase - 2'd1) : (r_phase + 2'd1);
            n_ticks = step_delay;
            n_taken = (start_ok ? '0 : r_taken) + 16'd1;
        end
    end

    always_comb begin
        o_result.coil_pattern = srsg_pkg::coil_lookup(n_phase);
        o_result.stepped      = do_step;
        o_result.busy_res     = n_moving;
        o_result.rejected     = is_start && r_moving;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise <= srsg_pkg::CRUISE_RESET;
            r_phase  <= '0;
            r_moving <= 1'b0;
            r_dir    <= 1'b0;
            r_ramped <= 1'b0;
            r_taken  <= '0;
            r_total  <= '0;
            r_fixed  <= '0;
            r_ticks  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cruise <= i_cfg_wr_data;
            end
            if (i_en) begin
                r_phase  <= n_phase;
                r_moving <= n_moving;
                r_dir    <= n_dir;
                r_ramped <= n_ramped;
                r_taken  <= n_taken;
                r_total  <= n_total;
                r_fixed  <= n_fixed;
                r_ticks  <= n_ticks;
            end
        end
    end

endmodule

@@ rtl/stepper_ramp_step_generator_top.sv @@
// ============================================================================
// stepper_ramp_step_generator_top
// Stepper motor step generator with table-driven acceleration ramps.
// ============================================================================
// Usage:
// Each item on the slave stream is either a one-millisecond tick or a command
// that starts a move; tuser carries the kind (tick, ramped start, constant
// start) and tdata the step count, direction and constant step delay.
// Every accepted item produces exactly one result item on the master stream:
// the coil drive byte after the item, whether a step was taken, whether the
// block is still busy and whether a start was refused because a move was
// already running.
// The cruise delay register is written through a simple write-enable port
// and should only be changed while no move is in progress.
// An input register holds the accepted item; the move state and the result register
// are then updated together by one short pass of logic when the result register
// is free or emptying.
// Throughput is one item per cycle while the receiver does not stall; the only
// loop is the move state itself.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more; after that s_axis_tready falls.
// Synchronous reset returns the phase to zero, ends any move, empties both
// registers and sets the cruise delay to six ticks.
// ============================================================================
module stepper_ramp_step_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: cruise delay in ticks.
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // Slave stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // step_count[15:0], direction[16], step_delay[24:17]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // Master stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // coil_pattern[7:0], stepped[8], busy_res[9],
                                       // rejected[10]
);

    logic                r_in_valid;
    srsg_pkg::t_item     r_in_item;
    logic                r_out_valid;
    srsg_pkg::t_result   r_out_res;
    srsg_pkg::t_result   core_res;
    srsg_pkg::t_item     in_item;
    logic                advance;
    logic                in_accept;

    // The second stage moves whenever the result register is free or emptying.
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_item.mode       = s_axis_tuser;
        in_item.step_count = s_axis_tdata[15:0];
        in_item.direction  = s_axis_tdata[16];
        in_item.step_delay = s_axis_tdata[24:17];
    end

    srsg_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_en          (r_in_valid && advance),
        .i_item        (r_in_item),
        .o_result      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= in_item;
        end
        if (advance && r_in_valid) begin
            r_out_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_res.rejected, r_out_res.busy_res,
                            r_out_res.stepped, r_out_res.coil_pattern};

endmodule

@@ rtl/srsg_checker.sv @@
// ============================================================================
// srsg_checker
// Port-level checks for the stepper ramp step generator.
// ============================================================================
module srsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // Nothing is presented on the first cycle after a reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // With the result register empty the input side must be open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output empty");

    // A step always leaves the block busy, and a refused start takes no step.
    a_step_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[9] && !m_axis_tdata[10])
        else $error("inconsistent step flags");

endmodule

bind stepper_ramp_step_generator_top srsg_checker u_srsg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
